// ===== rtl/core/tmwf_pkg.sv =====
// Shared constants, types and control structs for the trimmed mean window filter.
package tmwf_pkg;

  localparam int WINDOW_LENGTH_DEF = 40;
  localparam int SAMPLE_W          = 10;
  localparam int SUM_W             = 16;
  localparam int FRAC_W            = 6;
  localparam int DIVIDEND_W        = SUM_W + FRAC_W;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_SCAN   = 5'b00010,
    ST_TRIM   = 5'b00100,
    ST_DIVIDE = 5'b01000,
    ST_DONE   = 5'b10000
  } tmwf_state_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic trim;
    logic divide;
    logic out_load;
  } tmwf_cmd_t;

  typedef struct packed {
    logic scan_done;
    logic out_free;
  } tmwf_status_t;

endpackage

// ===== rtl/core/trimmed_mean_window_filter.sv =====
// Top level of the trimmed moving-mean filter over a circular window of samples.
// Each item carries one 10-bit sample, which overwrites the oldest slot of a window of
// WINDOW_LENGTH samples (all zero after reset). The result item gives the window sum minus one
// smallest and one largest entry, and that sum times 64 divided by WINDOW_LENGTH-2, truncated.
// One item is worked on at a time: while the result side keeps up, the time between accepted
// items is set by the window scan at one memory read per cycle, plus the trim, a reciprocal
// multiply for the division and the result load. A finished result sits in an output register,
// so the next sample is taken while it waits.
module trimmed_mean_window_filter #(
  parameter int WINDOW_LENGTH = tmwf_pkg::WINDOW_LENGTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // [9:0] sample, [15:10] zero
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata    // [15:0] trimmed_sum, [31:16] mean_q6
);
  import tmwf_pkg::*;

  tmwf_cmd_t        cmd;
  tmwf_status_t     st;
  logic [SUM_W-1:0] trimmed_sum;
  logic [SUM_W-1:0] mean_q6;

  tmwf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .st       (st),
    .cmd      (cmd)
  );

  tmwf_dp #(
    .WINDOW_LENGTH (WINDOW_LENGTH)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .st          (st),
    .sample      (s_tdata[SAMPLE_W-1:0]),
    .res_valid   (m_tvalid),
    .res_ready   (m_tready),
    .trimmed_sum (trimmed_sum),
    .mean_q6     (mean_q6)
  );

  assign m_tdata = {mean_q6, trimmed_sum};

endmodule

// ===== rtl/core/tmwf_ctrl.sv =====
// Controller state machine: sequences write, window scan, trim, divide and result load.
module tmwf_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_ready,
  input  tmwf_pkg::tmwf_status_t st,
  output tmwf_pkg::tmwf_cmd_t    cmd
);
  import tmwf_pkg::*;

  tmwf_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    state_next   = state;
    cmd          = '0;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (st.scan_done) begin
          state_next = ST_TRIM;
        end
      end
      ST_TRIM: begin
        cmd.trim   = 1'b1;
        state_next = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        cmd.divide = 1'b1;
        state_next = ST_DONE;
      end
      ST_DONE: begin
        // hold the result until the output register can take it
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ===== rtl/core/tmwf_dp.sv =====
// Datapath: sample window memory, sum/min/max scan, constant divider and output register.
module tmwf_dp #(
  parameter int WINDOW_LENGTH = tmwf_pkg::WINDOW_LENGTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  tmwf_pkg::tmwf_cmd_t            cmd,
  output tmwf_pkg::tmwf_status_t         st,
  input  logic [tmwf_pkg::SAMPLE_W-1:0]  sample,
  output logic                           res_valid,
  input  logic                           res_ready,
  output logic [tmwf_pkg::SUM_W-1:0]     trimmed_sum,
  output logic [tmwf_pkg::SUM_W-1:0]     mean_q6
);
  import tmwf_pkg::*;

  localparam int IDX_W    = $clog2(WINDOW_LENGTH);
  localparam int CNT_W    = $clog2(WINDOW_LENGTH + 1);
  localparam int RECIP_SH = DIVIDEND_W + $clog2(WINDOW_LENGTH - 2);
  localparam int RECIP_W  = DIVIDEND_W + 1;
  localparam int PROD_W   = DIVIDEND_W + RECIP_W;
  localparam logic [IDX_W-1:0]   LAST_SLOT = IDX_W'(WINDOW_LENGTH - 1);
  localparam logic [CNT_W-1:0]   WIN_CNT   = CNT_W'(WINDOW_LENGTH);
  localparam logic [RECIP_W-1:0] RECIP     =
    RECIP_W'(((1 << RECIP_SH) + (WINDOW_LENGTH - 2) - 1) / (WINDOW_LENGTH - 2));

  // window storage; valid bits stand in for the zero reset of the entries
  logic [SAMPLE_W-1:0]      mem [WINDOW_LENGTH];
  logic [WINDOW_LENGTH-1:0] valid;
  logic [IDX_W-1:0]         write_slot;

  logic [CNT_W-1:0]    rd_cnt;
  logic                rd_pend;
  logic [SAMPLE_W-1:0] rd_data;
  logic                rd_ok;
  logic [SAMPLE_W-1:0] rd_val;
  logic [IDX_W-1:0]    rd_idx;
  logic                rd_issue;

  logic [SUM_W-1:0]    total;
  logic [SAMPLE_W-1:0] lo;
  logic [SAMPLE_W-1:0] hi;
  logic [SUM_W-1:0]    trimmed;

  logic [PROD_W-1:0]   prod;
  logic [SUM_W-1:0]    quo;

  assign rd_idx   = rd_cnt[IDX_W-1:0];
  assign rd_issue = cmd.scan && (rd_cnt != WIN_CNT);
  assign rd_val   = rd_ok ? rd_data : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid      <= '0;
      write_slot <= '0;
    end else if (cmd.load) begin
      valid[write_slot] <= 1'b1;
      write_slot        <= (write_slot == LAST_SLOT) ? '0 : write_slot + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      mem[write_slot] <= sample;
    end
    if (rd_issue) begin
      rd_data <= mem[rd_idx];
      rd_ok   <= valid[rd_idx];
    end
  end

  // scan: one read issued per cycle, accumulated in the cycle after it is issued
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_cnt  <= '0;
      rd_pend <= 1'b0;
    end else if (cmd.load) begin
      rd_cnt  <= '0;
      rd_pend <= 1'b0;
    end else if (cmd.scan) begin
      rd_pend <= rd_issue;
      if (rd_issue) begin
        rd_cnt <= rd_cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      total <= '0;
      lo    <= '1;
      hi    <= '0;
    end else if (cmd.scan && rd_pend) begin
      total <= total + SUM_W'(rd_val);
      if (rd_val < lo) begin
        lo <= rd_val;
      end
      if (rd_val > hi) begin
        hi <= rd_val;
      end
    end
  end

  // divide by WINDOW_LENGTH-2: multiply by the rounded-up reciprocal, exact for every
  // dividend below 2^DIVIDEND_W
  assign prod = PROD_W'({trimmed, FRAC_W'(0)}) * PROD_W'(RECIP);

  always_ff @(posedge clk) begin
    if (cmd.trim) begin
      trimmed <= total - SUM_W'(lo) - SUM_W'(hi);
    end
    if (cmd.divide) begin
      quo <= prod[RECIP_SH +: SUM_W];
    end
  end

  // output register parts the result side from the scan
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.out_load) begin
      res_valid <= 1'b1;
    end else if (res_ready) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      trimmed_sum <= trimmed;
      mean_q6     <= quo;
    end
  end

  assign st.scan_done = (rd_cnt == WIN_CNT) && !rd_pend;
  assign st.out_free  = !res_valid || res_ready;

endmodule

// ===== rtl/core/tmwf_checker.sv =====
// Port-level checker for the trimmed mean window filter, bound to the top level.
module tmwf_checker #(
  parameter int WINDOW_LENGTH = tmwf_pkg::WINDOW_LENGTH_DEF
) (
  input logic        clk,
  input logic        rst,
  input logic        s_tvalid,
  input logic        s_tready,
  input logic [15:0] s_tdata,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [31:0] m_tdata
);
  localparam logic [31:0] DIV_C   = 32'(WINDOW_LENGTH - 2);
  localparam logic [31:0] MAX_SUM = 32'((WINDOW_LENGTH - 2) * 1023);

  logic [31:0] sum_w;
  logic [31:0] mean_w;

  assign sum_w  = {16'd0, m_tdata[15:0]};
  assign mean_w = {16'd0, m_tdata[31:16]};

  // after reset the block is empty and ready
  a_reset_state: assert property (@(posedge clk)
    !rst && $past(rst) |-> s_tready && !m_tvalid)
    else $error("not ready or result pending after reset");

  // one item in flight: ready drops after an accept
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("second item taken while one is in work");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

  // sum is at most (WINDOW_LENGTH-2)*1023; mean is the truncated quotient of the sum times 64
  a_mean: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> sum_w <= MAX_SUM && mean_w * DIV_C <= (sum_w << 6)
                 && (sum_w << 6) < (mean_w + 32'd1) * DIV_C)
    else $error("mean does not match trimmed sum");

endmodule

bind trimmed_mean_window_filter tmwf_checker #(
  .WINDOW_LENGTH (WINDOW_LENGTH)
) u_tmwf_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
